### hdl/mssl_pkg.sv
// mssl_pkg: shared types, codes and constants of the multi-servo slew limiter
// depends on nothing; used by mssl_cell, mssl_head and multi_servo_slew_limiter
package mssl_pkg;

   localparam int NUM_SERVOS_DEF = 8;

   // command codes
   localparam logic [2:0] CMD_SETUP  = 3'd0;
   localparam logic [2:0] CMD_MOVE   = 3'd1;
   localparam logic [2:0] CMD_WRITE  = 3'd2;
   localparam logic [2:0] CMD_DETACH = 3'd3;
   localparam logic [2:0] CMD_TICK   = 3'd4;

   // result kinds
   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_ANGLE  = 2'd1;
   localparam logic [1:0] KIND_TICK   = 2'd2;

   // register indexes
   localparam logic [1:0] REG_ACTIVE_COUNT = 2'd0;
   localparam logic [1:0] REG_MIN_INTERVAL = 2'd1;
   localparam logic [1:0] REG_DEF_SPEED    = 2'd2;

   localparam logic [7:0]  MIN_INTERVAL_RST = 8'd15;
   localparam logic [15:0] SPEED_RST        = 16'd120;
   localparam logic [7:0]  ANGLE_MAX        = 8'd180;

   // step = speed*elapsed/1000; at or above 256000 the step exceeds any angle gap
   localparam logic [33:0] PROD_BIG   = 34'd256000;
   localparam logic [18:0] RECIP_1000 = 19'd268436;   // ceil(2^28 / 1000)
   localparam int          RECIP_SHIFT = 28;

   typedef enum logic [2:0] {
      PASS_CMD,
      PASS_ELAP,
      PASS_MUL,
      PASS_DIV,
      PASS_UPD
   } pass_type;

   // one servo record as held by a ring cell
   typedef struct packed {
      logic [7:0]  current_angle;
      logic [7:0]  target_angle;
      logic [15:0] move_speed;
      logic [31:0] last_update;
      logic        attached;
      logic [7:0]  low_limit;
      logic [7:0]  high_limit;
      logic        go;          // servo steps on this tick
      logic        big;         // step reaches the target for sure
      logic [17:0] work;        // elapsed time, then speed*elapsed
      logic [7:0]  step;
   } rec_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [3:0] index;
      logic [7:0] angle;
      logic [7:0] target;
      logic       accepted;
      logic       last;
   } result_type;

   // controls handed to the head unit
   typedef struct packed {
      pass_type    pass;
      logic [2:0]  cmd;
      logic [3:0]  idx;
      logic [7:0]  angle;
      logic [15:0] speed;
      logic [7:0]  min_angle;
      logic [7:0]  max_angle;
      logic [31:0] now_ms;
      logic [7:0]  min_interval;
      logic [15:0] def_speed;
      logic [4:0]  cnt;
      logic [3:0]  pos;
   } head_ctl_type;

   typedef struct packed {
      logic       emit;
      result_type res;
      logic       hit;
      logic       hit_acc;
   } head_stat_type;

endpackage

### hdl/mssl_cell.sv
// mssl_cell: one ring cell holding the record of one servo
// depends on mssl_pkg
module mssl_cell (
   input  logic              clock,
   input  logic              reset,
   input  logic              shift_en,
   input  logic              clr_attached,
   input  mssl_pkg::rec_type rec_next,
   output mssl_pkg::rec_type rec
);

   mssl_pkg::rec_type rec_ff;
   mssl_pkg::rec_type rec_in;

   always_comb begin
      rec_in = rec_ff;
      if (shift_en) begin
         rec_in = rec_next;
      end
      if (clr_attached) begin
         rec_in.attached = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rec_ff.current_angle <= '0;
         rec_ff.target_angle  <= '0;
         rec_ff.move_speed    <= mssl_pkg::SPEED_RST;
         rec_ff.last_update   <= '0;
         rec_ff.attached      <= 1'b0;
      end else begin
         rec_ff <= rec_in;
      end
   end

   assign rec = rec_ff;

endmodule

### hdl/mssl_head.sv
// mssl_head: update unit at the head of the ring, one record per cycle while the ring shifts
// depends on mssl_pkg
module mssl_head (
   input  mssl_pkg::head_ctl_type  ctl,
   input  mssl_pkg::rec_type       rec_in,
   output mssl_pkg::rec_type       rec_out,
   output mssl_pkg::head_stat_type stat
);

   function automatic logic [7:0] clamp_angle(input logic [7:0] x, input logic [7:0] lo,
                                              input logic [7:0] hi);
      logic [7:0] r;
      if (x < lo) begin
         r = lo;
      end else if (x > hi) begin
         r = hi;
      end else begin
         r = x;
      end
      return r;
   endfunction

   logic        match;
   logic        in_cnt;
   logic        pos_in_cnt;
   logic [31:0] elapsed;
   logic [33:0] prod;
   logic [36:0] qprod;
   logic [8:0]  quot;
   logic [7:0]  mn_sat;
   logic [7:0]  mx_sat;
   logic [7:0]  clamped;
   logic [7:0]  setup_angle;
   logic [7:0]  diff;
   logic        upward;
   logic        reach;

   assign match      = (ctl.pos == ctl.idx);
   assign in_cnt     = ({1'b0, ctl.idx} < ctl.cnt);
   assign pos_in_cnt = ({1'b0, ctl.pos} < ctl.cnt);
   assign elapsed    = ctl.now_ms - rec_in.last_update;
   assign prod       = 34'(rec_in.move_speed) * 34'(rec_in.work);
   assign qprod      = 37'(rec_in.work) * 37'(mssl_pkg::RECIP_1000);
   assign quot       = qprod[mssl_pkg::RECIP_SHIFT +: 9];
   assign mn_sat     = (ctl.min_angle > mssl_pkg::ANGLE_MAX) ? mssl_pkg::ANGLE_MAX : ctl.min_angle;
   assign mx_sat     = (ctl.max_angle > mssl_pkg::ANGLE_MAX) ? mssl_pkg::ANGLE_MAX : ctl.max_angle;
   assign setup_angle = clamp_angle(ctl.angle, mn_sat, mx_sat);
   assign clamped    = clamp_angle(ctl.angle, rec_in.low_limit, rec_in.high_limit);
   assign upward     = (rec_in.current_angle < rec_in.target_angle);
   assign diff       = upward ? (rec_in.target_angle - rec_in.current_angle)
                              : (rec_in.current_angle - rec_in.target_angle);
   assign reach      = rec_in.big || (diff <= rec_in.step);

   always_comb begin
      rec_out = rec_in;
      stat    = '0;
      case (ctl.pass)
         mssl_pkg::PASS_CMD: begin
            if (match) begin
               stat.hit = 1'b1;
               case (ctl.cmd)
                  mssl_pkg::CMD_SETUP: begin
                     if (in_cnt) begin
                        rec_out.low_limit     = mn_sat;
                        rec_out.high_limit    = mx_sat;
                        rec_out.current_angle = setup_angle;
                        rec_out.target_angle  = setup_angle;
                        rec_out.move_speed    = (ctl.def_speed == '0) ? 16'd1 : ctl.def_speed;
                        rec_out.last_update   = ctl.now_ms;
                        rec_out.attached      = 1'b1;
                        stat.hit_acc          = 1'b1;
                     end
                  end
                  mssl_pkg::CMD_MOVE: begin
                     if (in_cnt && rec_in.attached) begin
                        rec_out.target_angle = clamped;
                        rec_out.move_speed   = (ctl.speed == '0) ? 16'd1 : ctl.speed;
                        stat.hit_acc         = 1'b1;
                     end
                  end
                  mssl_pkg::CMD_WRITE: begin
                     if (in_cnt && rec_in.attached) begin
                        rec_out.current_angle = clamped;
                        rec_out.target_angle  = clamped;
                        rec_out.last_update   = ctl.now_ms;
                        stat.hit_acc          = 1'b1;
                        stat.emit             = 1'b1;
                        stat.res.kind         = mssl_pkg::KIND_ANGLE;
                        stat.res.index        = ctl.idx;
                        stat.res.angle        = clamped;
                        stat.res.target       = clamped;
                        stat.res.accepted     = 1'b1;
                        stat.res.last         = 1'b0;
                     end
                  end
                  mssl_pkg::CMD_DETACH: begin
                     if (in_cnt && rec_in.attached) begin
                        rec_out.attached = 1'b0;
                        stat.hit_acc     = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         mssl_pkg::PASS_ELAP: begin
            rec_out.go   = pos_in_cnt && rec_in.attached &&
                           (rec_in.current_angle != rec_in.target_angle) &&
                           (elapsed >= 32'(ctl.min_interval));
            rec_out.big  = |elapsed[31:18];
            rec_out.work = elapsed[17:0];
         end
         mssl_pkg::PASS_MUL: begin
            rec_out.big  = rec_in.big || (prod >= mssl_pkg::PROD_BIG);
            rec_out.work = prod[17:0];
         end
         mssl_pkg::PASS_DIV: begin
            // work is below 256000 when big is clear, so the quotient fits 8 bits
            rec_out.step = (quot == '0) ? 8'd1 : quot[7:0];
         end
         mssl_pkg::PASS_UPD: begin
            if (rec_in.go) begin
               if (reach) begin
                  rec_out.current_angle = rec_in.target_angle;
               end else if (upward) begin
                  rec_out.current_angle = rec_in.current_angle + rec_in.step;
               end else begin
                  rec_out.current_angle = rec_in.current_angle - rec_in.step;
               end
               rec_out.last_update = ctl.now_ms;
               stat.emit         = 1'b1;
               stat.res.kind     = mssl_pkg::KIND_ANGLE;
               stat.res.index    = ctl.pos;
               stat.res.angle    = rec_out.current_angle;
               stat.res.target   = rec_in.target_angle;
               stat.res.accepted = 1'b1;
               stat.res.last     = 1'b0;
            end
         end
         default: begin
         end
      endcase
   end

endmodule

### hdl/multi_servo_slew_limiter.sv
// multi_servo_slew_limiter: top level, ring of servo cells, head unit, sequencer, csr port
// depends on mssl_pkg, mssl_cell, mssl_head
//
//   channel  | direction | handshake              | payload
//   ---------+-----------+------------------------+---------------------------------------
//   req_     | in        | req_valid / req_ready  | command, index, angle, speed, limits, now
//   rsp_     | out       | rsp_valid / rsp_ready  | kind, index, angle, target, accepted, last
//   csr_     | in/out    | apb psel/penable       | active_count, min_interval_ms, default_speed
//
// servo records circulate in a ring of NUM_SERVOS cells; each cycle the head record
// passes through the update unit and goes back in at the tail
// a command takes one ring rotation per word
// a tick takes four rotations (elapsed, multiply, divide, update), or none when no servo
// is in use (active count zero)
// rotation pauses while an angle word waits on a full output register
module multi_servo_slew_limiter #(
   parameter int NUM_SERVOS = mssl_pkg::NUM_SERVOS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request words
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic [3:0]  req_servo_index,
   input  logic [7:0]  req_angle,
   input  logic [15:0] req_speed,
   input  logic [7:0]  req_min_angle,
   input  logic [7:0]  req_max_angle,
   input  logic [31:0] req_now_ms,
   // response words
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [3:0]  rsp_out_index,
   output logic [7:0]  rsp_out_angle,
   output logic [7:0]  rsp_out_target,
   output logic        rsp_accepted,
   output logic        rsp_last,
   // configuration port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [3:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_FINAL
   } state_type;

   localparam logic [4:0] NUM_SERVOS_W = 5'(NUM_SERVOS);
   localparam logic [3:0] LAST_POS     = 4'(NUM_SERVOS - 1);

   // configuration registers
   logic [3:0]  active_count_ff, active_count_in;
   logic [7:0]  min_interval_ff, min_interval_in;
   logic [15:0] default_speed_ff, default_speed_in;
   logic        csr_wr;
   logic [4:0]  servo_cnt;

   // sequencer
   state_type            state_ff, state_in;
   mssl_pkg::pass_type   pass_ff, pass_in;
   logic [3:0]           pos_ff, pos_in;
   logic [2:0]           cmd_ff, cmd_in;
   logic [3:0]           idx_ff, idx_in;
   logic [7:0]           angle_ff, angle_in;
   logic [15:0]          speed_ff, speed_in;
   logic [7:0]           min_angle_ff, min_angle_in;
   logic [7:0]           max_angle_ff, max_angle_in;
   logic [31:0]          now_ff, now_in;
   logic [7:0]           sta_angle_ff, sta_angle_in;
   logic [7:0]           sta_target_ff, sta_target_in;
   logic                 acc_ff, acc_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   mssl_pkg::result_type res_ff, res_in;
   logic                 out_free;
   logic                 shift_en;

   // ring and head
   mssl_pkg::rec_type       ring [NUM_SERVOS];
   mssl_pkg::rec_type       head_rec;
   mssl_pkg::head_ctl_type  head_ctl;
   mssl_pkg::head_stat_type head_stat;

   // ---------------------------------------------------------------- csr port
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_comb begin
      active_count_in  = active_count_ff;
      min_interval_in  = min_interval_ff;
      default_speed_in = default_speed_ff;
      if (csr_wr) begin
         case (csr_paddr[3:2])
            mssl_pkg::REG_ACTIVE_COUNT: active_count_in  = csr_pwdata[3:0];
            mssl_pkg::REG_MIN_INTERVAL: min_interval_in  = csr_pwdata[7:0];
            mssl_pkg::REG_DEF_SPEED:    default_speed_in = csr_pwdata[15:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_count_ff  <= '0;
         min_interval_ff  <= mssl_pkg::MIN_INTERVAL_RST;
         default_speed_ff <= mssl_pkg::SPEED_RST;
      end else begin
         active_count_ff  <= active_count_in;
         min_interval_ff  <= min_interval_in;
         default_speed_ff <= default_speed_in;
      end
   end

   always_comb begin
      case (csr_paddr[3:2])
         mssl_pkg::REG_ACTIVE_COUNT: csr_prdata = {28'b0, active_count_ff};
         mssl_pkg::REG_MIN_INTERVAL: csr_prdata = {24'b0, min_interval_ff};
         mssl_pkg::REG_DEF_SPEED:    csr_prdata = {16'b0, default_speed_ff};
         default:                    csr_prdata = '0;
      endcase
   end

   // servos in use, capped at the ring size
   assign servo_cnt = ({1'b0, active_count_ff} > NUM_SERVOS_W) ? NUM_SERVOS_W
                                                               : {1'b0, active_count_ff};

   // ---------------------------------------------------------------- ring of cells
   // cell k takes from cell k+1, the tail cell takes the head unit's output
   for (genvar k = 0; k < NUM_SERVOS; k++) begin : g_cell
      mssl_pkg::rec_type cell_next;
      if (k == NUM_SERVOS - 1) begin : g_tail
         assign cell_next = head_rec;
      end else begin : g_mid
         assign cell_next = ring[k + 1];
      end
      mssl_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .shift_en     (shift_en),
         .clr_attached (csr_wr && (csr_paddr[3:2] == mssl_pkg::REG_ACTIVE_COUNT)),
         .rec_next     (cell_next),
         .rec          (ring[k])
      );
   end

   // head unit sees the record of servo pos_ff, the ring being aligned at rest
   assign head_ctl.pass         = pass_ff;
   assign head_ctl.cmd          = cmd_ff;
   assign head_ctl.idx          = idx_ff;
   assign head_ctl.angle        = angle_ff;
   assign head_ctl.speed        = speed_ff;
   assign head_ctl.min_angle    = min_angle_ff;
   assign head_ctl.max_angle    = max_angle_ff;
   assign head_ctl.now_ms       = now_ff;
   assign head_ctl.min_interval = min_interval_ff;
   assign head_ctl.def_speed    = default_speed_ff;
   assign head_ctl.cnt          = servo_cnt;
   assign head_ctl.pos          = pos_ff;

   mssl_head u_head (
      .ctl     (head_ctl),
      .rec_in  (ring[0]),
      .rec_out (head_rec),
      .stat    (head_stat)
   );

   // ---------------------------------------------------------------- sequencer
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // hold the ring while an angle word cannot go out
   assign shift_en  = (state_ff == ST_RUN) && (!head_stat.emit || out_free);
   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      pass_in       = pass_ff;
      pos_in        = pos_ff;
      cmd_in        = cmd_ff;
      idx_in        = idx_ff;
      angle_in      = angle_ff;
      speed_in      = speed_ff;
      min_angle_in  = min_angle_ff;
      max_angle_in  = max_angle_ff;
      now_in        = now_ff;
      sta_angle_in  = sta_angle_ff;
      sta_target_in = sta_target_ff;
      acc_in        = acc_ff;
      rsp_valid_in  = rsp_valid_ff;
      res_in        = res_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd_in        = req_command;
               idx_in        = req_servo_index;
               angle_in      = req_angle;
               speed_in      = req_speed;
               min_angle_in  = req_min_angle;
               max_angle_in  = req_max_angle;
               now_in        = req_now_ms;
               sta_angle_in  = '0;
               sta_target_in = '0;
               acc_in        = 1'b0;
               pos_in        = '0;
               if (req_command == mssl_pkg::CMD_TICK) begin
                  pass_in  = mssl_pkg::PASS_ELAP;
                  // no servo in use: nothing moves, only the tick word goes out
                  state_in = (servo_cnt == '0) ? ST_FINAL : ST_RUN;
               end else begin
                  pass_in  = mssl_pkg::PASS_CMD;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            if (head_stat.emit && out_free) begin
               rsp_valid_in = 1'b1;
               res_in       = head_stat.res;
            end
            if (shift_en) begin
               if (head_stat.hit) begin
                  // status carries the servo's angles after the command
                  sta_angle_in  = head_rec.current_angle;
                  sta_target_in = head_rec.target_angle;
                  acc_in        = head_stat.hit_acc;
               end
               if (pos_ff == LAST_POS) begin
                  pos_in = '0;
                  case (pass_ff)
                     mssl_pkg::PASS_ELAP: pass_in = mssl_pkg::PASS_MUL;
                     mssl_pkg::PASS_MUL:  pass_in = mssl_pkg::PASS_DIV;
                     mssl_pkg::PASS_DIV:  pass_in = mssl_pkg::PASS_UPD;
                     default:             state_in = ST_FINAL;
                  endcase
               end else begin
                  pos_in = pos_ff + 4'd1;
               end
            end
         end
         ST_FINAL: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               res_in.last  = 1'b1;
               if (cmd_ff == mssl_pkg::CMD_TICK) begin
                  res_in.kind     = mssl_pkg::KIND_TICK;
                  res_in.index    = '0;
                  res_in.angle    = '0;
                  res_in.target   = '0;
                  res_in.accepted = (servo_cnt != '0);
               end else begin
                  res_in.kind     = mssl_pkg::KIND_STATUS;
                  res_in.index    = idx_ff;
                  res_in.angle    = sta_angle_ff;
                  res_in.target   = sta_target_ff;
                  res_in.accepted = acc_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pass_ff      <= mssl_pkg::PASS_CMD;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pass_ff       <= pass_in;
         pos_ff        <= pos_in;
         rsp_valid_ff  <= rsp_valid_in;
         cmd_ff        <= cmd_in;
         idx_ff        <= idx_in;
         angle_ff      <= angle_in;
         speed_ff      <= speed_in;
         min_angle_ff  <= min_angle_in;
         max_angle_ff  <= max_angle_in;
         now_ff        <= now_in;
         sta_angle_ff  <= sta_angle_in;
         sta_target_ff <= sta_target_in;
         acc_ff        <= acc_in;
         res_ff        <= res_in;
      end
   end

   // response word
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_kind       = res_ff.kind;
   assign rsp_out_index  = res_ff.index;
   assign rsp_out_angle  = res_ff.angle;
   assign rsp_out_target = res_ff.target;
   assign rsp_accepted   = res_ff.accepted;
   assign rsp_last       = res_ff.last;

endmodule
